[hdl/lsom_pkg.sv]
// Shared types and codes for the layer stacking-order manager.
// No dependencies; used by layer_stack_order_manager_unit and lsom_cell in hdl/.
package lsom_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_SET   = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_PEEK  = 2'd3
  } kind_t;

  // Result status codes.
  localparam logic STATUS_DONE       = 1'b0;
  localparam logic STATUS_ALLOC_FAIL = 1'b1;

  // Level of a hidden layer.
  localparam int LEVEL_HIDDEN = -1;

  // Where a cell takes its next content from during a shift.
  typedef enum logic {
    DIR_FROM_BELOW = 1'b0,
    DIR_FROM_ABOVE = 1'b1
  } shift_dir_t;

  // Broadcast control for the row of level cells.
  typedef struct packed {
    logic       active;
    logic       load;
    shift_dir_t dir;
  } cell_ctl_t;

endpackage

[hdl/layer_stack_order_manager_unit.sv]
// Layer stacking-order manager: a row of level cells plus a small sequencer.
// A transaction runs through the accept/find/plan/move/emit states in turn; the
// next one is accepted only after the emit state has loaded the result.
// The output register lets the next transaction be taken while a result waits.
// Reset (rst, synchronous): every layer free, nothing shown; no clearing pass.
// Depends on lsom_pkg, lsom_enc, lsom_cell.
module layer_stack_order_manager_unit #(
  parameter int LAYER_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [7:0] layer_id, [17:8] requested_level, rest zero
  input  logic [1:0]  s_tuser,  // [1:0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // [0] status, [8:1] result_layer, [17:9] applied_level,
                                // [26:18] shown_count, [27] redraw_needed, rest zero
);

  localparam int N  = LAYER_COUNT;
  localparam int IW = $clog2(N);
  // level arithmetic must hold -1 .. N and the 10-bit signed request
  localparam int CW = ((IW + 2) > 10) ? (IW + 2) : 10;
  localparam int MW = (IW > 8) ? IW : 8;
  localparam logic signed [CW-1:0] HIDDEN = CW'(lsom_pkg::LEVEL_HIDDEN);
  localparam logic signed [CW-1:0] ONE    = CW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_PLAN,
    ST_MOVE,
    ST_EMIT
  } state_t;

  state_t state;

  // request held for the whole transaction
  lsom_pkg::kind_t      kind_q;
  logic [7:0]           id_q;
  logic signed [9:0]    req_q;
  logic                 valid_q;   // addressed layer exists and is in use

  // search vectors captured at accept
  logic [N-1:0]         hit_q;
  logic [N-1:0]         free1h_q;

  // pool state
  logic [N-1:0]         in_use;
  logic signed [CW-1:0] top;

  // find stage results
  logic signed [CW-1:0] old_q;
  logic [IW-1:0]        alloc_idx_q;
  logic                 alloc_ok_q;

  // plan stage results: cell control and result fields
  lsom_pkg::cell_ctl_t  ctl;
  logic signed [CW-1:0] lo_q;
  logic signed [CW-1:0] hi_q;
  logic signed [CW-1:0] lvl_q;
  logic                 res_status;
  logic [7:0]           res_layer;
  logic signed [CW-1:0] res_level;
  logic                 res_redraw;

  // output register fields
  logic                 out_status;
  logic [7:0]           out_layer;
  logic [8:0]           out_level;
  logic [8:0]           out_shown;
  logic                 out_redraw;

  // cell row wiring
  logic [IW-1:0]        content [N];
  logic [N-1:0]         hit;
  logic [IW-1:0]        load_layer;

  // accept-side helpers
  logic [IW-1:0]        s_id_ix;
  logic                 s_id_ok;
  logic [N-1:0]         free_vec;
  logic [N-1:0]         free1h;

  // find-side helpers
  logic [IW-1:0]        old_idx;
  logic                 old_shown;
  logic [IW-1:0]        alloc_idx;
  logic                 alloc_ok;

  // plan-side helpers
  logic signed [CW-1:0] req_ext;
  logic signed [CW-1:0] lim;
  logic signed [CW-1:0] t0;
  logic signed [CW-1:0] t1;
  logic signed [CW-1:0] tgt;
  logic                 do_move;
  logic [IW-1:0]        id_ix_q;
  lsom_pkg::cell_ctl_t  ctl_next;
  logic signed [CW-1:0] lo_next;
  logic signed [CW-1:0] hi_next;
  logic signed [CW-1:0] top_next;

  assign s_tready = (state == ST_IDLE);

  assign s_id_ix  = IW'(s_tdata[7:0]);
  assign s_id_ok  = ({24'd0, s_tdata[7:0]} < 32'(N)) && in_use[s_id_ix];
  // lowest free layer, isolated as a one-hot word
  assign free_vec = ~in_use;
  assign free1h   = free_vec & (~free_vec + N'(1));

  assign id_ix_q    = IW'(id_q);
  assign load_layer = id_ix_q;

  lsom_enc #(.N(N), .W(IW)) u_enc_hit (
    .onehot (hit_q),
    .idx    (old_idx),
    .any    (old_shown)
  );

  lsom_enc #(.N(N), .W(IW)) u_enc_free (
    .onehot (free1h_q),
    .idx    (alloc_idx),
    .any    (alloc_ok)
  );

  // Row of level cells; cell h holds the layer shown at level h and shifts
  // to or from its neighbours when a layer is moved.
  for (genvar h = 0; h < N; h++) begin : g_cell
    logic [IW-1:0] below_c;
    logic [IW-1:0] above_c;
    if (h == 0) begin : g_first
      assign below_c = '0;
    end else begin : g_mid_lo
      assign below_c = content[h-1];
    end
    if (h == N - 1) begin : g_last
      assign above_c = '0;
    end else begin : g_mid_hi
      assign above_c = content[h+1];
    end
    lsom_cell #(.LEVEL(h), .IW(IW), .CW(CW), .MW(MW)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .lo         (lo_q),
      .hi         (hi_q),
      .lvl        (lvl_q),
      .load_layer (load_layer),
      .below      (below_c),
      .above      (above_c),
      .probe_id   (s_tdata[7:0]),
      .top        (top),
      .content    (content[h]),
      .hit        (hit[h])
    );
  end

  // Clamp the target level: a shown layer tops out at the current top,
  // a hidden one may go one above it; nothing goes below hidden.
  // Then work out the shift window and the new top; inputs stay put from
  // plan through move, so the move cycle can take top_next directly.
  always_comb begin
    req_ext = CW'(req_q);
    lim     = (old_q >= 0) ? top : (top + ONE);
    t0      = (kind_q == lsom_pkg::KIND_SET) ? req_ext : HIDDEN;
    t1      = (t0 > lim) ? lim : t0;
    tgt     = (t1 < HIDDEN) ? HIDDEN : t1;
    do_move = valid_q && ((kind_q == lsom_pkg::KIND_SET) || (kind_q == lsom_pkg::KIND_FREE))
              && (tgt != old_q);

    ctl_next = '{active: do_move, load: 1'b0, dir: lsom_pkg::DIR_FROM_BELOW};
    lo_next  = ONE;
    hi_next  = HIDDEN;
    top_next = top;
    if (old_q > tgt) begin
      if (tgt >= 0) begin
        // sink: layers between drop in from below
        ctl_next = '{active: do_move, load: 1'b1, dir: lsom_pkg::DIR_FROM_BELOW};
        lo_next  = tgt + ONE;
        hi_next  = old_q;
      end else begin
        // hide: layers above close the gap
        ctl_next = '{active: do_move, load: 1'b0, dir: lsom_pkg::DIR_FROM_ABOVE};
        lo_next  = old_q;
        hi_next  = top - ONE;
        top_next = do_move ? (top - ONE) : top;
      end
    end else if (old_q < tgt) begin
      if (old_q >= 0) begin
        // raise: layers between come down from above
        ctl_next = '{active: do_move, load: 1'b1, dir: lsom_pkg::DIR_FROM_ABOVE};
        lo_next  = old_q;
        hi_next  = tgt - ONE;
      end else begin
        // show: insert, everything above moves up
        ctl_next = '{active: do_move, load: 1'b1, dir: lsom_pkg::DIR_FROM_BELOW};
        lo_next  = tgt + ONE;
        hi_next  = top + ONE;
        top_next = do_move ? (top + ONE) : top;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_use     <= '0;
      top        <= HIDDEN;
      ctl        <= '{active: 1'b0, load: 1'b0, dir: lsom_pkg::DIR_FROM_BELOW};
      m_tvalid   <= 1'b0;
    end else begin
      // the emit state reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind_q   <= lsom_pkg::kind_t'(s_tuser);
            id_q     <= s_tdata[7:0];
            req_q    <= s_tdata[17:8];
            valid_q  <= s_id_ok;
            hit_q    <= hit;
            free1h_q <= free1h;
            state    <= ST_FIND;
          end
        end
        ST_FIND: begin
          old_q       <= old_shown ? $signed(CW'(old_idx)) : HIDDEN;
          alloc_idx_q <= alloc_idx;
          alloc_ok_q  <= alloc_ok;
          state       <= ST_PLAN;
        end
        ST_PLAN: begin
          lvl_q      <= tgt;
          ctl        <= ctl_next;
          lo_q       <= lo_next;
          hi_q       <= hi_next;
          res_redraw <= do_move;
          res_status <= ((kind_q == lsom_pkg::KIND_ALLOC) && !alloc_ok_q) ?
                        lsom_pkg::STATUS_ALLOC_FAIL : lsom_pkg::STATUS_DONE;
          if (kind_q == lsom_pkg::KIND_ALLOC) begin
            res_layer <= alloc_ok_q ? 8'(alloc_idx_q) : 8'd0;
          end else begin
            res_layer <= id_q;
          end
          if (valid_q && (kind_q == lsom_pkg::KIND_SET)) begin
            res_level <= tgt;
          end else if (valid_q && (kind_q == lsom_pkg::KIND_PEEK)) begin
            res_level <= old_q;
          end else begin
            res_level <= HIDDEN;
          end
          state <= ST_MOVE;
        end
        ST_MOVE: begin
          // cells shift this cycle under ctl
          ctl <= '{active: 1'b0, load: 1'b0, dir: lsom_pkg::DIR_FROM_BELOW};
          top <= top_next;
          if ((kind_q == lsom_pkg::KIND_ALLOC) && alloc_ok_q) begin
            in_use[alloc_idx_q] <= 1'b1;
          end
          if ((kind_q == lsom_pkg::KIND_FREE) && valid_q) begin
            in_use[id_ix_q] <= 1'b0;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_layer  <= res_layer;
            out_level  <= 9'(res_level);
            out_shown  <= 9'(top + ONE);
            out_redraw <= res_redraw;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {4'd0, out_redraw, out_shown, out_level, out_layer, out_status};

endmodule

[hdl/lsom_enc.sv]
// One-hot to index encoder with an any-set flag.
// Depends on nothing; used by the top level for hit and free vectors.
module lsom_enc #(
  parameter int N = 256,
  parameter int W = 8
) (
  input  logic [N-1:0] onehot,
  output logic [W-1:0] idx,
  output logic         any
);

  always_comb begin
    idx = '0;
    for (int h = 0; h < N; h++) begin
      if (onehot[h]) begin
        idx = idx | W'(h);
      end
    end
    any = |onehot;
  end

endmodule

[hdl/lsom_cell.sv]
// One level of the ordered stacking table: holds the layer at that level.
// Depends on lsom_pkg (cell_ctl_t, shift_dir_t).
module lsom_cell #(
  parameter int LEVEL = 0,
  parameter int IW    = 8,
  parameter int CW    = 10,
  parameter int MW    = 8
) (
  input  logic                  clk,
  input  lsom_pkg::cell_ctl_t   ctl,
  input  logic signed [CW-1:0]  lo,
  input  logic signed [CW-1:0]  hi,
  input  logic signed [CW-1:0]  lvl,
  input  logic [IW-1:0]         load_layer,
  input  logic [IW-1:0]         below,
  input  logic [IW-1:0]         above,
  input  logic [7:0]            probe_id,
  input  logic signed [CW-1:0]  top,
  output logic [IW-1:0]         content,
  output logic                  hit
);

  localparam logic signed [CW-1:0] H = CW'(LEVEL);

  logic in_range;

  assign in_range = (lo <= H) && (H <= hi);
  // only levels up to the top hold a shown layer
  assign hit = (H <= top) && (MW'(content) == MW'(probe_id));

  always_ff @(posedge clk) begin
    if (ctl.active) begin
      if (in_range) begin
        content <= (ctl.dir == lsom_pkg::DIR_FROM_BELOW) ? below : above;
      end else if (ctl.load && (lvl == H)) begin
        content <= load_layer;
      end
    end
  end

endmodule

[test/tb_layer_stack_order_manager_unit.sv]
// Testbench for layer_stack_order_manager_unit: random and hand-picked requests are
// checked against an in-bench model of the layer table, with idling on both streams.
// Depends on lsom_pkg and the layer_stack_order_manager_unit RTL.
module tb_layer_stack_order_manager_unit;

  localparam int POOL_SIZE    = 256;
  localparam int LONG_HOLD    = 200;     // receiver hold-off, long enough to back up the input
  localparam int DRAIN_CYCLES = 24;      // idle wait past the last result, before the summary
  localparam int CYCLE_LIMIT  = 400000;

  // One result as it appears on m_tdata.
  typedef struct packed {
    logic              status;
    logic [7:0]        layer;
    logic signed [8:0] level;
    logic [8:0]        shown;
    logic              redraw;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [7:0] layer_id, [17:8] requested_level
  logic [1:0]  s_tuser;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [0] status, [8:1] layer, [17:9] level, [26:18] shown, [27] redraw

  // Model of the stacking table
  bit         layer_live [POOL_SIZE];
  int         layer_lvl  [POOL_SIZE];   // present level, -1 hidden
  logic [7:0] lvl_owner  [POOL_SIZE];   // layer sitting at each shown level
  int         top_lvl;

  outcome_t   pending_outcomes[$];
  int         fault_count;
  int         requests_sent;
  int         results_seen;
  int         alloc_fails_seen;
  int         peak_shown;
  int         cycle_count;
  bit         in_burst;
  bit         out_burst;
  int         hold_token;
  int         hold_seen;

  always #4 clk = ~clk;

  layer_stack_order_manager_unit #(
    .LAYER_COUNT(POOL_SIZE)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // ---------------------------------------------------------------- model

  function automatic void seat_layer(int h, int layer);
    if (h >= 0 && h < POOL_SIZE && layer < POOL_SIZE) begin
      lvl_owner[h]     = layer[7:0];
      layer_lvl[layer] = h;
    end
  endfunction

  function automatic int owner_at(int h);
    return (h >= 0 && h < POOL_SIZE) ? int'(lvl_owner[h]) : 0;
  endfunction

  // Moves a live layer towards the requested level; 1 if the order changed.
  function automatic bit restack_layer(int layer, int req);
    int src_lvl;
    int dst_lvl;
    int h;
    src_lvl = layer_lvl[layer];
    dst_lvl = req;
    // a shown layer can go no higher than the present top
    if (src_lvl >= 0) begin
      if (dst_lvl > top_lvl) dst_lvl = top_lvl;
    end else if (dst_lvl > top_lvl + 1) begin
      dst_lvl = top_lvl + 1;
    end
    if (dst_lvl < lsom_pkg::LEVEL_HIDDEN) dst_lvl = lsom_pkg::LEVEL_HIDDEN;

    if (src_lvl > dst_lvl) begin
      if (dst_lvl >= 0) begin
        for (h = src_lvl; h > dst_lvl; h--) seat_layer(h, owner_at(h - 1));
        seat_layer(dst_lvl, layer);
      end else begin
        // hiding: close the gap from above
        for (h = src_lvl; h < top_lvl; h++) seat_layer(h, owner_at(h + 1));
        layer_lvl[layer] = lsom_pkg::LEVEL_HIDDEN;
        top_lvl--;
      end
      return 1'b1;
    end
    if (src_lvl < dst_lvl) begin
      if (src_lvl >= 0) begin
        for (h = src_lvl; h < dst_lvl; h++) seat_layer(h, owner_at(h + 1));
        seat_layer(dst_lvl, layer);
      end else begin
        // showing: open a slot, everything above moves up one
        for (h = top_lvl; h >= dst_lvl; h--) seat_layer(h + 1, owner_at(h));
        seat_layer(dst_lvl, layer);
        top_lvl++;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t apply_request(lsom_pkg::kind_t kind, logic [7:0] id,
                                             logic [9:0] req_bits);
    outcome_t o;
    int       req;
    int       lvl;
    int       count;
    bit       ok;
    req      = $signed(req_bits);
    ok       = (id < POOL_SIZE) && layer_live[id];
    lvl      = lsom_pkg::LEVEL_HIDDEN;
    o.status = lsom_pkg::STATUS_DONE;
    o.layer  = id;
    o.redraw = 1'b0;
    case (kind)
      lsom_pkg::KIND_ALLOC: begin
        o.status = lsom_pkg::STATUS_ALLOC_FAIL;
        o.layer  = '0;
        for (int i = 0; i < POOL_SIZE && o.status == lsom_pkg::STATUS_ALLOC_FAIL; i++) begin
          if (!layer_live[i]) begin
            layer_live[i] = 1'b1;
            layer_lvl[i]  = lsom_pkg::LEVEL_HIDDEN;
            o.status      = lsom_pkg::STATUS_DONE;
            o.layer       = i[7:0];
          end
        end
      end
      lsom_pkg::KIND_SET: begin
        if (ok) begin
          o.redraw = restack_layer(id, req);
          lvl      = layer_lvl[id];
        end
      end
      lsom_pkg::KIND_FREE: begin
        if (ok) begin
          if (layer_lvl[id] >= 0) o.redraw = restack_layer(id, lsom_pkg::LEVEL_HIDDEN);
          layer_live[id] = 1'b0;
        end
      end
      default: begin
        if (ok) lvl = layer_lvl[id];
      end
    endcase
    count   = top_lvl + 1;
    o.level = lvl[8:0];
    o.shown = count[8:0];
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int idle_draw(bit burst);
    return burst ? 0 : $urandom_range(11);
  endfunction

  // Offers one request and predicts its result at the accepting edge.
  task automatic send_request(input lsom_pkg::kind_t kind, input int id, input int req);
    int gap;
    gap = idle_draw(in_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, req[9:0], id[7:0]};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_outcomes.push_back(apply_request(kind, id[7:0], req[9:0]));
    requests_sent++;
  endtask

  function automatic int pick_live_layer();
    int ids[$];
    for (int i = 0; i < POOL_SIZE; i++) if (layer_live[i]) ids.push_back(i);
    if (ids.size() == 0) return -1;
    return ids[$urandom_range(ids.size() - 1)];
  endfunction

  // Mostly well-formed level moves on live layers, with some noise.
  task automatic random_request(input int alloc_pct, input int free_pct);
    int pick;
    int id;
    int req;
    pick = $urandom_range(99);
    id   = pick_live_layer();
    req  = int'($urandom_range(1023)) - 512;
    if (id < 0 || pick < alloc_pct) begin
      send_request(lsom_pkg::KIND_ALLOC, $urandom_range(255), req);
    end else if (pick < alloc_pct + free_pct) begin
      send_request(lsom_pkg::KIND_FREE, id, req);
    end else if (pick < alloc_pct + free_pct + 5) begin
      send_request(lsom_pkg::KIND_PEEK, $urandom_range(1) ? id : $urandom_range(255), req);
    end else if (pick < alloc_pct + free_pct + 10) begin
      // any layer at all, often one that is not allocated
      send_request((pick % 2) ? lsom_pkg::KIND_SET : lsom_pkg::KIND_FREE,
                   $urandom_range(255), req);
    end else begin
      case ($urandom_range(9))
        0: req = lsom_pkg::LEVEL_HIDDEN;
        1: req = 511;
        2: req = -2 - int'($urandom_range(510));
        3: req = top_lvl;
        4: req = layer_lvl[id];   // no move expected
        5: ;                      // anywhere in the field's range
        default: req = $urandom_range(top_lvl + 1, 0);
      endcase
      send_request(lsom_pkg::KIND_SET, id, req);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Corner cases on a near-empty pool.
  task automatic test_corner_requests();
    send_request(lsom_pkg::KIND_SET,   0,   0);      // layer not allocated
    send_request(lsom_pkg::KIND_FREE,  255, 511);    // layer not allocated
    send_request(lsom_pkg::KIND_PEEK,  255, -512);   // free layer reads as hidden
    send_request(lsom_pkg::KIND_ALLOC, 0,   0);
    send_request(lsom_pkg::KIND_ALLOC, 170, 341);
    send_request(lsom_pkg::KIND_ALLOC, 85,  -342);
    send_request(lsom_pkg::KIND_SET,   0,   511);    // hidden layer clamped to one above top
    send_request(lsom_pkg::KIND_SET,   1,   -512);   // already hidden: no change
    send_request(lsom_pkg::KIND_SET,   1,   511);
    send_request(lsom_pkg::KIND_SET,   2,   0);      // insert at the bottom
    send_request(lsom_pkg::KIND_SET,   2,   511);    // shown layer clamped to the top
    send_request(lsom_pkg::KIND_SET,   2,   2);      // same level: no redraw
    send_request(lsom_pkg::KIND_SET,   0,   1);
    send_request(lsom_pkg::KIND_PEEK,  0,   0);
    send_request(lsom_pkg::KIND_SET,   1,   -1);     // hide a shown layer
    send_request(lsom_pkg::KIND_FREE,  0,   0);      // free while shown
    send_request(lsom_pkg::KIND_FREE,  1,   0);      // free while hidden
    send_request(lsom_pkg::KIND_ALLOC, 255, 0);      // lowest free layer comes back
    send_request(lsom_pkg::KIND_SET,   0,   -2);
    send_request(lsom_pkg::KIND_SET,   0,   0);
    send_request(lsom_pkg::KIND_FREE,  2,   0);
    send_request(lsom_pkg::KIND_FREE,  0,   0);
  endtask

  // Allocate past the end of the pool.
  task automatic test_fill_pool();
    repeat (POOL_SIZE + 2)
      send_request(lsom_pkg::KIND_ALLOC, $urandom_range(255), $urandom_range(1023));
  endtask

  // Show every layer in shuffled order so the stack reaches its full height.
  task automatic test_show_all();
    int order[POOL_SIZE];
    int j;
    int t;
    for (int i = 0; i < POOL_SIZE; i++) order[i] = i;
    for (int i = POOL_SIZE - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < POOL_SIZE; i++)
      send_request(lsom_pkg::KIND_SET, order[i], $urandom_range(511, top_lvl + 1));
  endtask

  // Receiver stops for a long while; requests keep coming back to back.
  task automatic test_output_hold();
    in_burst = 1'b1;
    hold_token++;
    repeat (16) random_request(5, 5);
    in_burst = 1'b0;
  endtask

  // Random traffic in rounds that push the pool towards full and empty.
  task automatic test_random_mix();
    int alloc_pct[4] = '{30, 15, 8, 20};
    int free_pct[4]  = '{10, 15, 25, 12};
    for (int r = 0; r < 4; r++) begin
      for (int n = 0; n < 250; n++) begin
        if (n % 40 == 0) begin
          in_burst  = ($urandom_range(3) == 0);
          out_burst = ($urandom_range(3) == 0);
        end
        random_request(alloc_pct[r], free_pct[r]);
      end
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_result(logic [31:0] word);
    outcome_t got;
    outcome_t want;
    got.status = word[0];
    got.layer  = word[8:1];
    got.level  = word[17:9];
    got.shown  = word[26:18];
    got.redraw = word[27];
    results_seen++;
    if (got.status == lsom_pkg::STATUS_ALLOC_FAIL) alloc_fails_seen++;
    if (got.shown > peak_shown) peak_shown = got.shown;
    if (pending_outcomes.size() == 0) begin
      fault_count++;
      if (fault_count <= 10) $display("result with no request outstanding: tdata=%h", word);
      return;
    end
    want = pending_outcomes.pop_front();
    if (got !== want) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("result %0d differs:", results_seen);
        $display("  expected status=%0d layer=%0d level=%0d shown=%0d redraw=%0d",
                 want.status, want.layer, want.level, want.shown, want.redraw);
        $display("  actual   status=%0d layer=%0d level=%0d shown=%0d redraw=%0d",
                 got.status, got.layer, got.level, got.shown, got.redraw);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
  end

  // Result sink: random stall per transaction, plus the long hold when asked for.
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = idle_draw(out_burst);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid && hold_token == hold_seen) @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles, %0d results outstanding",
             cycle_count, pending_outcomes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    s_tuser          = lsom_pkg::KIND_ALLOC;
    fault_count      = 0;
    requests_sent    = 0;
    results_seen     = 0;
    alloc_fails_seen = 0;
    peak_shown       = 0;
    in_burst         = 1'b0;
    out_burst        = 1'b0;
    hold_token       = 0;
    hold_seen        = 0;
    top_lvl          = lsom_pkg::LEVEL_HIDDEN;
    for (int i = 0; i < POOL_SIZE; i++) begin
      layer_live[i] = 1'b0;
      layer_lvl[i]  = lsom_pkg::LEVEL_HIDDEN;
      lvl_owner[i]  = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_corner_requests();
    test_fill_pool();
    test_show_all();
    test_output_hold();
    test_random_mix();

    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked in %0d cycles", requests_sent, results_seen,
             cycle_count);
    $display("allocation failures %0d, tallest stack %0d layers, faults %0d",
             alloc_fails_seen, peak_shown, fault_count);
    if (fault_count == 0 && pending_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[layer_stack_order_manager_unit.f]
hdl/lsom_pkg.sv
hdl/lsom_enc.sv
hdl/lsom_cell.sv
hdl/layer_stack_order_manager_unit.sv
test/tb_layer_stack_order_manager_unit.sv
